[hw/rtl/ffbd_pkg.sv]
// Package for the fixed-frame byte deframer.
// Holds frame geometry, reset marker values, register indexes and the cell control type.
// No dependencies.
`default_nettype none

package ffbd_pkg;

   // Default number of byte cells in the window
   localparam int WINDOW_DEPTH_DEF = 20;

   // Start byte, eight payload bytes, stop byte
   localparam int FRAME_SPAN = 10;

   // Marker values after reset
   localparam logic [7:0] START_MARKER_RST = 8'd7;
   localparam logic [7:0] STOP_MARKER_RST  = 8'd8;

   // Configuration register indexes
   localparam logic [7:0] CSR_START_MARKER = 8'd0;
   localparam logic [7:0] CSR_STOP_MARKER  = 8'd1;

   // Request kinds
   localparam logic MODE_APPEND = 1'b0;
   localparam logic MODE_POLL   = 1'b1;

   // Control that is broadcast to every cell of the chain
   typedef struct packed {
      logic       shift;    // take the neighbor's byte
      logic       rx_load;  // load rx_data if this cell is the write slot
      logic [7:0] rx_data;
   } cell_ctl_type;

endpackage

`default_nettype wire

[hw/rtl/ffbd_cell.sv]
// One byte cell of the deframer window chain.
// Depends on ffbd_pkg for the cell control type.
`default_nettype none

module ffbd_cell (
   input  wire                   clock,
   input  ffbd_pkg::cell_ctl_type ctl,
   input  wire                   slot_sel,
   input  wire  [7:0]            next_data,
   output logic [7:0]            data
);

   logic [7:0] data_ff;
   logic [7:0] data_in;

   // Shift from the neighbor, or load a new byte into the write slot
   always_comb begin
      data_in = data_ff;
      if (ctl.shift) begin
         data_in = next_data;
      end else if (ctl.rx_load && slot_sel) begin
         data_in = ctl.rx_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

`default_nettype wire

[hw/rtl/fixed_frame_byte_deframer_top.sv]
// Fixed-frame byte deframer: a chain of byte cells plus a scan sequencer.
// A byte request is taken only while idle. A poll rotates the cell chain one position a
// cycle until a frame is at the head or a full turn is done; a found frame and the bytes
// before it are then rotated out. The result is registered once the response slot is free.
// Reset (synchronous, active high) clears fill count, sequencer and result valid and sets
// the markers to 7 and 8; window bytes are not cleared. Depends on ffbd_pkg and ffbd_cell.
`default_nettype none

module fixed_frame_byte_deframer_top #(
   parameter int WINDOW_DEPTH = ffbd_pkg::WINDOW_DEPTH_DEF
) (
   input  wire                clock,
   input  wire                reset,
   // request channel
   input  wire                req_valid,
   output logic               req_stall,
   input  wire                req_mode,
   input  wire  [7:0]         req_rx_byte,
   // response channel
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic               rsp_frame_found,
   output logic [31:0]        rsp_parameter_number,
   output logic signed [31:0] rsp_parameter_value,
   // configuration channel
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [7:0]         csr_index,
   input  wire  [7:0]         csr_data
);

   localparam int KW = $clog2(WINDOW_DEPTH + 1);
   localparam int DW = $clog2(ffbd_pkg::FRAME_SPAN + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DROP, ST_RESP} state_type;

   state_type         state_ff, state_in;
   logic [KW-1:0]     fill_ff, fill_in;
   logic [KW-1:0]     rot_ff, rot_in;
   logic [DW-1:0]     drop_cnt_ff, drop_cnt_in;
   logic [KW-1:0]     fill_pend_ff, fill_pend_in;
   logic              cap_found_ff, cap_found_in;
   logic [31:0]       cap_num_ff, cap_num_in;
   logic [31:0]       cap_val_ff, cap_val_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [31:0]       rsp_num_ff, rsp_num_in;
   logic [31:0]       rsp_val_ff, rsp_val_in;
   logic [7:0]        start_marker_ff, stop_marker_ff;

   ffbd_pkg::cell_ctl_type cell_ctl;
   logic [7:0]        cell_data [WINDOW_DEPTH];
   logic [7:0]        tail_next;
   logic              req_fire;
   logic              out_free;
   logic              frame_hit;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= ffbd_pkg::START_MARKER_RST;
         stop_marker_ff  <= ffbd_pkg::STOP_MARKER_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            ffbd_pkg::CSR_START_MARKER: start_marker_ff <= csr_data;
            ffbd_pkg::CSR_STOP_MARKER:  stop_marker_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // Byte cell chain: cell i takes cell i+1, the last cell takes the new byte or wraps
   assign tail_next = (state_ff == ST_IDLE) ? req_rx_byte : cell_data[0];

   for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
      logic [7:0] nbr;
      if (i == WINDOW_DEPTH - 1) begin : g_last
         assign nbr = tail_next;
      end else begin : g_mid
         assign nbr = cell_data[i + 1];
      end
      ffbd_cell u_cell (
         .clock     (clock),
         .ctl       (cell_ctl),
         .slot_sel  (fill_ff == KW'(i)),
         .next_data (nbr),
         .data      (cell_data[i])
      );
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Frame check at the head of the rotated chain, bounded by the filled bytes
   assign frame_hit = (({1'b0, rot_ff} + (KW+1)'(ffbd_pkg::FRAME_SPAN)) <= {1'b0, fill_ff})
                      && (cell_data[0] == start_marker_ff)
                      && (cell_data[ffbd_pkg::FRAME_SPAN - 1] == stop_marker_ff);

   // Sequencer next state
   always_comb begin
      state_in          = state_ff;
      fill_in           = fill_ff;
      rot_in            = rot_ff;
      drop_cnt_in       = drop_cnt_ff;
      fill_pend_in      = fill_pend_ff;
      cap_found_in      = cap_found_ff;
      cap_num_in        = cap_num_ff;
      cap_val_in        = cap_val_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_found_in      = rsp_found_ff;
      rsp_num_in        = rsp_num_ff;
      rsp_val_in        = rsp_val_ff;
      cell_ctl.shift    = 1'b0;
      cell_ctl.rx_load  = 1'b0;
      cell_ctl.rx_data  = req_rx_byte;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == ffbd_pkg::MODE_APPEND) begin
                  // Drop the oldest byte and shift the new one in when full, else write at the fill slot
                  if (fill_ff == KW'(WINDOW_DEPTH)) begin
                     cell_ctl.shift = 1'b1;
                  end else begin
                     cell_ctl.rx_load = 1'b1;
                     fill_in = fill_ff + KW'(1);
                  end
               end else begin
                  state_in     = ST_SCAN;
                  rot_in       = '0;
                  cap_found_in = 1'b0;
                  cap_num_in   = '0;
                  cap_val_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            if (frame_hit) begin
               cap_found_in = 1'b1;
               cap_num_in   = {cell_data[4], cell_data[3], cell_data[2], cell_data[1]};
               cap_val_in   = {cell_data[8], cell_data[7], cell_data[6], cell_data[5]};
               fill_pend_in = fill_ff - rot_ff - KW'(ffbd_pkg::FRAME_SPAN);
               drop_cnt_in  = DW'(ffbd_pkg::FRAME_SPAN);
               state_in     = ST_DROP;
            end else begin
               // Advance one position; a full turn restores the window
               cell_ctl.shift = 1'b1;
               rot_in = rot_ff + KW'(1);
               if (rot_ff == KW'(WINDOW_DEPTH - 1)) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_DROP: begin
            // Rotate the frame bytes out of the head
            cell_ctl.shift = 1'b1;
            drop_cnt_in = drop_cnt_ff - DW'(1);
            if (drop_cnt_ff == DW'(1)) begin
               fill_in  = fill_pend_ff;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = cap_found_ff;
               rsp_num_in   = cap_num_ff;
               rsp_val_in   = cap_val_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rot_ff       <= '0;
         drop_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rot_ff       <= rot_in;
         drop_cnt_ff  <= drop_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      fill_pend_ff <= fill_pend_in;
      cap_found_ff <= cap_found_in;
      cap_num_ff   <= cap_num_in;
      cap_val_ff   <= cap_val_in;
      rsp_found_ff <= rsp_found_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_val_ff   <= rsp_val_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frame_found      = rsp_found_ff;
   assign rsp_parameter_number = rsp_num_ff;
   assign rsp_parameter_value  = signed'(rsp_val_ff);

   // Fill count never exceeds the window
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= KW'(WINDOW_DEPTH))
      else $error("fill count above window depth");

   // Scan rotation stays within one turn
   a_rot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rot_ff < KW'(WINDOW_DEPTH)))
      else $error("scan rotation beyond window");

   // The last drop step commits the reduced fill count
   a_drop_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DROP && drop_cnt_ff == DW'(1)) |=>
         (fill_ff == $past(fill_pend_ff) && state_ff == ST_RESP))
      else $error("drop did not commit fill count");

   // A ready result slot is loaded and the sequencer returns to idle
   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && out_free) |=>
         (rsp_valid_ff && rsp_found_ff == $past(cap_found_ff) && state_ff == ST_IDLE))
      else $error("result not loaded");

   // Drop is entered only with a found frame captured
   a_drop_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DROP) |-> cap_found_ff)
      else $error("drop without frame");

endmodule

`default_nettype wire

[tb/fixed_frame_byte_deframer_top_test.sv]
// Self-checking bench for fixed_frame_byte_deframer_top: table-driven requests, then
// random frame traffic under several marker settings, checked against a window predictor.
// Depends on ffbd_pkg and the deframer RTL.

module fixed_frame_byte_deframer_top_test;

   localparam int WIN_DEPTH  = ffbd_pkg::WINDOW_DEPTH_DEF;
   localparam int DRAIN      = WIN_DEPTH + 16;
   localparam int LONG_HOLD  = 300;
   localparam int CYCLE_CAP  = 400000;
   localparam int PHASE_REQS = 160;

   typedef struct packed {
      logic               found;
      logic [31:0]        number;
      logic signed [31:0] value;
   } frame_rsp_type;

   typedef struct packed {
      logic          mode;
      logic [7:0]    data;
      logic          known;   // response typed in below
      frame_rsp_type want;
   } step_row_type;

   // Directed requests; typed responses only where they are obvious
   localparam step_row_type DIRECTED_STEPS [0:24] = '{
      '{ffbd_pkg::MODE_POLL,   8'h00, 1'b1, '{1'b0, 32'h0000_0000, 32'h0000_0000}},
      '{ffbd_pkg::MODE_APPEND, 8'h07, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'hFF, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'hFF, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'hFF, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'hFF, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h00, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h00, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h00, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h80, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h08, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_POLL,   8'hFF, 1'b1, '{1'b1, 32'hFFFF_FFFF, 32'h8000_0000}},
      '{ffbd_pkg::MODE_POLL,   8'h00, 1'b1, '{1'b0, 32'h0000_0000, 32'h0000_0000}},
      '{ffbd_pkg::MODE_APPEND, 8'h07, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h11, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h22, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h33, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h44, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h55, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h66, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h77, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_APPEND, 8'h08, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_POLL,   8'h5A, 1'b1, '{1'b0, 32'h0000_0000, 32'h0000_0000}},
      '{ffbd_pkg::MODE_APPEND, 8'h08, 1'b0, '{1'b0, 32'h0, 32'h0}},
      '{ffbd_pkg::MODE_POLL,   8'hA5, 1'b1, '{1'b1, 32'h4433_2211, 32'h0877_6655}}
   };

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_mode;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_stall;
   logic               rsp_frame_found;
   logic [31:0]        rsp_parameter_number;
   logic signed [31:0] rsp_parameter_value;
   logic               csr_valid;
   logic               csr_ready;
   logic [7:0]         csr_index;
   logic [7:0]         csr_data;

   // Predictor state
   logic [7:0]    win_bytes [WIN_DEPTH];
   int            win_fill;
   logic [7:0]    start_q;
   logic [7:0]    stop_q;
   frame_rsp_type due_frames [$];

   // Run control and statistics
   bit no_idle;
   bit long_hold_start;
   int cycles;
   int mismatches;
   int reqs_sent;
   int polls_sent;
   int rsp_seen;
   int frames_seen;
   int marker_sets;

   fixed_frame_byte_deframer_top u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_mode             (req_mode),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_frame_found      (rsp_frame_found),
      .rsp_parameter_number (rsp_parameter_number),
      .rsp_parameter_value  (rsp_parameter_value),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Append one byte, dropping the oldest when the window is full
   function automatic void take_byte(input logic [7:0] b);
      if (win_fill >= WIN_DEPTH) begin
         for (int k = 0; k < WIN_DEPTH - 1; k++) win_bytes[k] = win_bytes[k + 1];
         win_fill = WIN_DEPTH - 1;
      end
      win_bytes[win_fill] = b;
      win_fill++;
   endfunction

   // Find the first start/stop pair that bounds one frame span, report it and consume through stop
   function automatic frame_rsp_type search_frame();
      frame_rsp_type r;
      int            hit;
      int            n;
      r   = '0;
      hit = -1;
      for (int i = 0; hit < 0 && i + ffbd_pkg::FRAME_SPAN - 1 < win_fill; i++) begin
         if (win_bytes[i] == start_q &&
             win_bytes[i + ffbd_pkg::FRAME_SPAN - 1] == stop_q) hit = i;
      end
      if (hit >= 0) begin
         r.found  = 1'b1;
         r.number = {win_bytes[hit + 4], win_bytes[hit + 3],
                     win_bytes[hit + 2], win_bytes[hit + 1]};
         r.value  = {win_bytes[hit + 8], win_bytes[hit + 7],
                     win_bytes[hit + 6], win_bytes[hit + 5]};
         n = hit + ffbd_pkg::FRAME_SPAN;
         for (int k = 0; k < win_fill - n; k++) win_bytes[k] = win_bytes[k + n];
         win_fill -= n;
      end
      return r;
   endfunction

   // Mostly random bytes, sometimes a marker value
   function automatic logic [7:0] rnd_byte();
      case ($urandom_range(9))
         0: return start_q;
         1: return stop_q;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Offer one request, hold it until accepted, then advance the predictor
   task automatic send_request(input logic m, input logic [7:0] d,
                               input logic known, input frame_rsp_type want);
      int            gap;
      frame_rsp_type got;
      gap = 0;
      while (!no_idle && $urandom_range(99) < 10) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= m;
      req_rx_byte <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      reqs_sent++;
      if (m == ffbd_pkg::MODE_POLL) begin
         polls_sent++;
         got = search_frame();
         due_frames.push_back(known ? want : got);
      end else begin
         take_byte(d);
      end
   endtask

   task automatic push_byte(input logic [7:0] b);
      send_request(ffbd_pkg::MODE_APPEND, b, 1'b0, '0);
   endtask

   task automatic poll_window();
      send_request(ffbd_pkg::MODE_POLL, 8'($urandom_range(255)), 1'b0, '0);
   endtask

   // Let all responses arrive and the block settle
   task automatic drain_idle();
      req_valid <= 1'b0;
      while (due_frames.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // Write a stray index, then both markers; only the two known indexes take effect
   task automatic set_markers(input logic [7:0] s, input logic [7:0] p,
                              input logic [7:0] junk_idx);
      logic [7:0] idx [3];
      logic [7:0] val [3];
      idx = '{junk_idx, ffbd_pkg::CSR_START_MARKER, ffbd_pkg::CSR_STOP_MARKER};
      val = '{8'($urandom_range(255)), s, p};
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[k];
         csr_data  <= val[k];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
         if (idx[k] == ffbd_pkg::CSR_START_MARKER) start_q = val[k];
         else if (idx[k] == ffbd_pkg::CSR_STOP_MARKER) stop_q = val[k];
      end
      csr_valid <= 1'b0;
      marker_sets++;
   endtask

   // Mostly whole frames with random payload, plus broken frames, noise bursts and bare polls
   task automatic send_random(input int budget);
      int         sel;
      int         n;
      int         stop_at;
      stop_at = reqs_sent + budget;
      while (reqs_sent < stop_at) begin
         sel = $urandom_range(99);
         if (sel < 55) begin
            n = $urandom_range(3);
            repeat (n) push_byte(rnd_byte());
            push_byte(start_q);
            repeat (ffbd_pkg::FRAME_SPAN - 2) push_byte(rnd_byte());
            push_byte(stop_q);
            poll_window();
         end else if (sel < 70) begin
            push_byte(start_q);
            n = $urandom_range(ffbd_pkg::FRAME_SPAN - 2);
            repeat (n) push_byte(rnd_byte());
            if ($urandom_range(1)) push_byte(stop_q ^ 8'($urandom_range(1, 255)));
            poll_window();
         end else if (sel < 85) begin
            n = $urandom_range(1, WIN_DEPTH + 5);
            repeat (n) push_byte(8'($urandom_range(255)));
         end else begin
            poll_window();
         end
      end
   endtask

   // Response stall: random, one long hold-off on request, none while no_idle is set
   initial begin : rsp_stall_gen
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_start) begin
            long_hold_start = 1'b0;
            hold_left = LONG_HOLD - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !no_idle && ($urandom_range(99) < 10);
         end
      end
   end

   // Compare each accepted response against the oldest expectation
   always @(posedge clock) begin : rsp_check
      frame_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (rsp_frame_found === 1'b1) frames_seen++;
         if (due_frames.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected response: found %b number %h value %0d",
                        rsp_frame_found, rsp_parameter_number, rsp_parameter_value);
            mismatches++;
         end else begin
            want = due_frames.pop_front();
            if (rsp_frame_found !== want.found || rsp_parameter_number !== want.number ||
                rsp_parameter_value !== want.value) begin
               if (mismatches < 10)
                  $display("mismatch at response %0d: found %b/%b number %h/%h value %0d/%0d",
                           rsp_seen, want.found, rsp_frame_found, want.number,
                           rsp_parameter_number, want.value, rsp_parameter_value);
               mismatches++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, due_frames.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_mode    <= ffbd_pkg::MODE_APPEND;
      req_rx_byte <= 8'h00;
      csr_valid   <= 1'b0;
      csr_index   <= ffbd_pkg::CSR_START_MARKER;
      csr_data    <= 8'h00;
      no_idle         = 1'b0;
      long_hold_start = 1'b0;
      cycles      = 0;
      mismatches  = 0;
      reqs_sent   = 0;
      polls_sent  = 0;
      rsp_seen    = 0;
      frames_seen = 0;
      marker_sets = 0;
      win_fill    = 0;
      start_q     = ffbd_pkg::START_MARKER_RST;
      stop_q      = ffbd_pkg::STOP_MARKER_RST;
      for (int k = 0; k < WIN_DEPTH; k++) win_bytes[k] = 8'h00;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed table at reset markers
      for (int r = 0; r < 25; r++)
         send_request(DIRECTED_STEPS[r].mode, DIRECTED_STEPS[r].data,
                      DIRECTED_STEPS[r].known, DIRECTED_STEPS[r].want);
      drain_idle();

      // Reset markers, with one long response hold-off
      long_hold_start = 1'b1;
      send_random(PHASE_REQS);
      drain_idle();

      // Marker extremes
      set_markers(8'h00, 8'hFF, 8'hFF);
      send_random(PHASE_REQS);
      drain_idle();

      // Opposite extremes, no idling on either side
      set_markers(8'hFF, 8'h00, 8'($urandom_range(2, 255)));
      no_idle = 1'b1;
      send_random(PHASE_REQS);
      drain_idle();
      no_idle = 1'b0;

      // Same value opens and closes a frame
      begin : same_marker
         logic [7:0] m;
         m = 8'($urandom_range(255));
         set_markers(m, m, 8'($urandom_range(2, 255)));
      end
      send_random(PHASE_REQS);
      drain_idle();

      // Random markers
      set_markers(8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(2, 255)));
      send_random(PHASE_REQS);
      drain_idle();

      $display("covered %0d requests (%0d polls), %0d responses with %0d frames recovered",
               reqs_sent, polls_sent, rsp_seen, frames_seen);
      $display("across %0d marker settings, %0d mismatches", marker_sets + 1, mismatches);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[fixed_frame_byte_deframer_top.f]
hw/rtl/ffbd_pkg.sv
hw/rtl/ffbd_cell.sv
hw/rtl/fixed_frame_byte_deframer_top.sv
tb/fixed_frame_byte_deframer_top_test.sv
